FILE: src/ekfsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekfsd_pkg: shared definitions for the K-line frame sync decoder
// Constants of the start sequence and frame decoding, register indexes,
// default sizes and the result record passed from the core to the top level.
// ----------------------------------------------------------------------------
package ekfsd_pkg;

	// Default sizes of the start sequence, frame window and speed averaging.
	localparam int START_SEQ_LEN_DEF = 61;
	localparam int FRAME_LEN_DEF     = 5;
	localparam int SPEED_SAMPLES_DEF = 8;

	// Protocol and scaling constants.
	localparam logic [7:0]  START_BYTE     = 8'h3E;
	localparam logic [7:0]  DIAG_BYTE      = 8'hCD;
	localparam logic [5:0]  RPM_SCALE      = 6'd50;
	localparam logic [7:0]  COOLANT_OFFSET = 8'd30;
	localparam logic [7:0]  TOP_SPEED_INIT = 8'd10;

	// Configuration register map.
	localparam int          CFG_IDX_W         = 2;
	localparam int          TIMER_W           = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_DIS = 2'd1;
	localparam logic [TIMER_W-1:0]   OFF_TIMEOUT_RST = 24'd5000;

	// Width of the packed result beat.
	localparam int OUT_DATA_W = 56;

	// One result item.
	typedef struct packed {
		logic        went_off;
		logic [7:0]  peak_speed;
		logic [7:0]  error_code;
		logic [7:0]  coolant_value;
		logic        speed_new;
		logic [7:0]  speed_value;
		logic [13:0] rpm_value;
		logic        link_running;
		logic        diag_mode;
		logic        frame_ok;
	} result_t;

endpackage

FILE: src/ekfsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekfsd_core: link state and frame decoding
// Holds the link phase, sliding byte window, silence timer and measurement
// registers, and updates them for one byte or tick per step.
// ----------------------------------------------------------------------------
module ekfsd_core #(
	parameter int START_SEQ_LEN = ekfsd_pkg::START_SEQ_LEN_DEF,
	parameter int FRAME_LEN     = ekfsd_pkg::FRAME_LEN_DEF,
	parameter int SPEED_SAMPLES = ekfsd_pkg::SPEED_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            cmd,
	input  logic [7:0]                      rx_byte,
	input  logic [ekfsd_pkg::TIMER_W-1:0]   off_timeout_ticks,
	input  logic                            timeout_disable,
	output ekfsd_pkg::result_t              result
);

	localparam int CNT_MAX = (START_SEQ_LEN > FRAME_LEN) ? START_SEQ_LEN : FRAME_LEN;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int IDX_W   = $clog2(SPEED_SAMPLES + 1);
	localparam int TW      = ekfsd_pkg::TIMER_W;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_START = 3'b010,
		PH_RUN   = 3'b100
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             diag_q, diag_d;
	logic [7:0]       win_q [FRAME_LEN];
	logic [7:0]       win_d [FRAME_LEN];
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [TW-1:0]    timer_q, timer_d, timer_inc;
	logic             armed_q, armed_d;
	logic [7:0]       ssum_q, ssum_d;
	logic [IDX_W-1:0] sidx_q, sidx_d;
	logic [IDX_W:0]   sidx_inc;
	logic [7:0]       speed_q, speed_d;
	logic [13:0]      rpm_q, rpm_d;
	logic [7:0]       cool_q, cool_d;
	logic [7:0]       err_q, err_d;
	logic [7:0]       top_q, top_d;
	logic [7:0]       peak_q, peak_d;
	logic [7:0]       fb0, fb1, fb2, fb3;
	logic [7:0]       chk_sum, any_bits;
	logic             frame_ok, speed_new, went_off;

	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign timer_inc = (timer_q != {TW{1'b1}}) ? timer_q + TW'(1) : timer_q;
	assign sidx_inc  = {1'b0, sidx_q} + (IDX_W+1)'(1);

	// Next state for one byte or tick.
	always_comb begin
		phase_d   = phase_q;
		diag_d    = diag_q;
		win_d     = win_q;
		cnt_d     = cnt_q;
		timer_d   = timer_q;
		armed_d   = armed_q;
		ssum_d    = ssum_q;
		sidx_d    = sidx_q;
		speed_d   = speed_q;
		rpm_d     = rpm_q;
		cool_d    = cool_q;
		err_d     = err_q;
		top_d     = top_q;
		peak_d    = peak_q;
		frame_ok  = 1'b0;
		speed_new = 1'b0;
		went_off  = 1'b0;
		chk_sum   = '0;
		any_bits  = '0;
		fb0       = '0;
		fb1       = '0;
		fb2       = '0;
		fb3       = '0;

		if (cmd) begin
			// Tick: count silence and drop the link on timeout.
			if (armed_q) begin
				timer_d = timer_inc;
				if (!timeout_disable && (timer_inc > off_timeout_ticks)) begin
					phase_d  = PH_IDLE;
					diag_d   = 1'b0;
					for (int k = 0; k < FRAME_LEN; k++) win_d[k] = '0;
					cnt_d    = '0;
					timer_d  = '0;
					armed_d  = 1'b0;
					went_off = 1'b1;
				end
			end
		end else begin
			timer_d = '0;
			armed_d = 1'b1;
			case (phase_q)
				PH_RUN: begin
					// Slide or fill the window.
					if (cnt_q >= CNT_W'(FRAME_LEN)) begin
						for (int k = 0; k < FRAME_LEN - 1; k++) win_d[k] = win_q[k+1];
						win_d[FRAME_LEN-1] = rx_byte;
					end else begin
						for (int k = 0; k < FRAME_LEN; k++) begin
							if (cnt_q == CNT_W'(k)) win_d[k] = rx_byte;
						end
						cnt_d = cnt_inc;
					end
					// Checksum over the window contents.
					for (int k = 0; k < FRAME_LEN; k++) begin
						any_bits = any_bits | win_d[k];
						if (k < FRAME_LEN - 1) chk_sum = chk_sum + win_d[k];
						if (k == 0) fb0 = win_d[k];
						if (k == 1) fb1 = win_d[k];
						if (k == 2) fb2 = win_d[k];
						if (k == 3) fb3 = win_d[k];
					end
					if ((cnt_d == CNT_W'(FRAME_LEN)) && (any_bits != '0) &&
					    (chk_sum == win_d[FRAME_LEN-1])) begin
						frame_ok = 1'b1;
						if (!diag_q) begin
							// Peak is taken before this frame's speed update.
							if (speed_q > top_q) begin
								top_d  = speed_q;
								peak_d = speed_q;
							end
							rpm_d  = 14'(fb0) * 14'(ekfsd_pkg::RPM_SCALE);
							ssum_d = ssum_q + fb1;
							sidx_d = sidx_inc[IDX_W-1:0];
							if (sidx_inc >= (IDX_W+1)'(SPEED_SAMPLES)) begin
								speed_d   = ssum_q + fb1;
								ssum_d    = '0;
								sidx_d    = '0;
								speed_new = 1'b1;
							end
							err_d  = fb2;
							cool_d = fb3 - ekfsd_pkg::COOLANT_OFFSET;
						end
						for (int k = 0; k < FRAME_LEN; k++) win_d[k] = '0;
						cnt_d = '0;
					end
				end
				PH_START: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= CNT_W'(START_SEQ_LEN)) begin
						diag_d  = (rx_byte == ekfsd_pkg::DIAG_BYTE);
						phase_d = PH_RUN;
						cnt_d   = '0;
						for (int k = 0; k < FRAME_LEN; k++) win_d[k] = '0;
					end
				end
				PH_IDLE: begin
					if (rx_byte == ekfsd_pkg::START_BYTE) begin
						phase_d = PH_START;
						cnt_d   = CNT_W'(1);
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result fields show the state after this item.
	always_comb begin
		result.frame_ok      = frame_ok;
		result.diag_mode     = diag_d;
		result.link_running  = (phase_d == PH_RUN);
		result.rpm_value     = rpm_d;
		result.speed_value   = speed_d;
		result.speed_new     = speed_new;
		result.coolant_value = cool_d;
		result.error_code    = err_d;
		result.peak_speed    = peak_d;
		result.went_off      = went_off;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			diag_q  <= 1'b0;
			for (int k = 0; k < FRAME_LEN; k++) win_q[k] <= '0;
			cnt_q   <= '0;
			timer_q <= '0;
			armed_q <= 1'b0;
			ssum_q  <= '0;
			sidx_q  <= '0;
			speed_q <= '0;
			rpm_q   <= '0;
			cool_q  <= '0;
			err_q   <= '0;
			top_q   <= ekfsd_pkg::TOP_SPEED_INIT;
			peak_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			diag_q  <= diag_d;
			win_q   <= win_d;
			cnt_q   <= cnt_d;
			timer_q <= timer_d;
			armed_q <= armed_d;
			ssum_q  <= ssum_d;
			sidx_q  <= sidx_d;
			speed_q <= speed_d;
			rpm_q   <= rpm_d;
			cool_q  <= cool_d;
			err_q   <= err_d;
			top_q   <= top_d;
			peak_q  <= peak_d;
		end
	end

endmodule

FILE: src/ecu_kline_frame_sync_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_kline_frame_sync_decoder_unit: K-line frame sync and decoder
// Pipeline: an accepted input beat passes the input register, then is decoded
// into the output register as the link state is updated.
// Throughput: one beat per cycle while the result sink keeps up.
// Reset: asynchronous, clears the link, window and measurements at once;
// the timeout register resets to 5000 ticks with the timeout enabled.
// ----------------------------------------------------------------------------
module ecu_kline_frame_sync_decoder_unit #(
	parameter int START_SEQ_LEN = ekfsd_pkg::START_SEQ_LEN_DEF,
	parameter int FRAME_LEN     = ekfsd_pkg::FRAME_LEN_DEF,
	parameter int SPEED_SAMPLES = ekfsd_pkg::SPEED_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
	input  logic                                s_axis_tuser,  // [0] cmd
	// Result stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] frame_ok, [1] diag_mode, [2] link_running, [16:3] rpm_value,
	// [24:17] speed_value, [25] speed_new, [33:26] coolant_value,
	// [41:34] error_code, [49:42] peak_speed, [50] went_off, [55:51] zero
	output logic [ekfsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ekfsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ekfsd_pkg::TIMER_W-1:0]       cfg_data
);

	localparam int RES_W = $bits(ekfsd_pkg::result_t);

	logic                           valid_s1;
	logic                           cmd_s1;
	logic [7:0]                     byte_s1;
	logic                           advance;
	logic                           out_valid_q;
	ekfsd_pkg::result_t             out_q;
	ekfsd_pkg::result_t             res;
	logic [ekfsd_pkg::TIMER_W-1:0]  off_timeout_q;
	logic                           timeout_dis_q;

	// The input stage moves on when the output register is free or draining.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_timeout_q <= ekfsd_pkg::OFF_TIMEOUT_RST;
			timeout_dis_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == ekfsd_pkg::CFG_OFF_TIMEOUT) off_timeout_q <= cfg_data;
			if (cfg_index == ekfsd_pkg::CFG_TIMEOUT_DIS) timeout_dis_q <= cfg_data[0];
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	ekfsd_core #(
		.START_SEQ_LEN (START_SEQ_LEN),
		.FRAME_LEN     (FRAME_LEN),
		.SPEED_SAMPLES (SPEED_SAMPLES)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.cmd               (cmd_s1),
		.rx_byte           (byte_s1),
		.off_timeout_ticks (off_timeout_q),
		.timeout_disable   (timeout_dis_q),
		.result            (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The held reading starts from the reset measurements.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(ekfsd_pkg::OUT_DATA_W - RES_W)'(0), out_q};

	// A timeout beat leaves the link down and reports no frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.went_off |-> !out_q.link_running && !out_q.diag_mode
		&& !out_q.frame_ok)
		else $error("timeout beat shows an active link or a frame");

	// A fresh speed value only comes with an accepted frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.speed_new |-> out_q.frame_ok && out_q.link_running)
		else $error("speed refreshed without a frame");

	// Measurements change only on a normal-mode frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !res.frame_ok |=> $stable(out_q.rpm_value) && $stable(out_q.peak_speed))
		else $error("measurements changed without a frame");

	// A result is never overwritten while it waits for the sink.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !advance)
		else $error("stalled result overwritten");

endmodule

FILE: verif/ecu_kline_frame_sync_decoder_unit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_kline_frame_sync_decoder_unit_check: result checker for the K-line decoder
// Watches the input, result and configuration channels of the decoder. Every
// accepted input beat is run through a cycle-free model of the link state,
// window and measurements; the reading it predicts is queued and compared
// field by field with the next result beat. Failures are counted for the top.
// ----------------------------------------------------------------------------
module ecu_kline_frame_sync_decoder_unit_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
	input  logic                             s_axis_tuser,  // [0] cmd
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] frame_ok, [1] diag_mode, [2] link_running, [16:3] rpm_value,
	// [24:17] speed_value, [25] speed_new, [33:26] coolant_value,
	// [41:34] error_code, [49:42] peak_speed, [50] went_off, [55:51] zero
	input  logic [ekfsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [ekfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ekfsd_pkg::TIMER_W-1:0]    cfg_data,
	output int                               fail_count,
	output int                               pending
);

	localparam int START_LEN = ekfsd_pkg::START_SEQ_LEN_DEF;
	localparam int FRAME_N   = ekfsd_pkg::FRAME_LEN_DEF;
	localparam int SPEED_N   = ekfsd_pkg::SPEED_SAMPLES_DEF;
	localparam int TW        = ekfsd_pkg::TIMER_W;

	typedef enum logic [2:0] {
		LINK_IDLE  = 3'b001,
		LINK_START = 3'b010,
		LINK_RUN   = 3'b100
	} link_state_t;

	// Configuration as last written.
	logic [TW-1:0]      tmo_ticks;
	logic               tmo_off;

	// Link tracking.
	link_state_t        link_st;
	logic               diag_q;
	logic [7:0]         win [FRAME_N];
	int unsigned        win_cnt;
	logic [TW-1:0]      silence_q;
	logic               armed_q;

	// Measurements, kept across a link drop.
	logic [7:0]         spd_acc;
	int unsigned        spd_cnt;
	logic [7:0]         speed_q;
	logic [13:0]        rpm_q;
	logic [7:0]         cool_q;
	logic [7:0]         err_q;
	logic [7:0]         top_q;
	logic [7:0]         peak_q;

	ekfsd_pkg::result_t expected_readings[$];
	ekfsd_pkg::result_t next_r;
	ekfsd_pkg::result_t want_r;
	ekfsd_pkg::result_t got_r;
	int                 bad = 0;
	int                 beat_no = 0;

	function automatic void clear_window();
		for (int k = 0; k < FRAME_N; k++)
			win[k] = 8'h00;
		win_cnt = 0;
	endfunction

	function automatic void drop_link();
		link_st   = LINK_IDLE;
		diag_q    = 1'b0;
		silence_q = '0;
		armed_q   = 1'b0;
		clear_window();
	endfunction

	function automatic logic [7:0] byte_at(int k);
		return (k < FRAME_N) ? win[k] : 8'h00;
	endfunction

	// Advances the model by one beat and returns the reading it produces.
	function automatic ekfsd_pkg::result_t decode_beat(logic tick, logic [7:0] rx);
		ekfsd_pkg::result_t r;
		logic [7:0]         csum;
		logic               nonzero;
		r = '0;
		if (tick) begin
			// Silence counting saturates and only runs once a byte has been seen.
			if (armed_q) begin
				if (silence_q != '1)
					silence_q = silence_q + 1'b1;
				if (!tmo_off && silence_q > tmo_ticks) begin
					drop_link();
					r.went_off = 1'b1;
				end
			end
		end else begin
			silence_q = '0;
			armed_q   = 1'b1;
			case (link_st)
			LINK_RUN: begin
				// Slide the window once it is full.
				if (win_cnt >= FRAME_N) begin
					for (int k = 0; k < FRAME_N - 1; k++)
						win[k] = win[k+1];
					win[FRAME_N-1] = rx;
				end else begin
					win[win_cnt] = rx;
					win_cnt++;
				end
				if (win_cnt == FRAME_N) begin
					csum    = 8'h00;
					nonzero = 1'b0;
					for (int k = 0; k < FRAME_N; k++) begin
						nonzero = nonzero | (|win[k]);
						if (k < FRAME_N - 1)
							csum = csum + win[k];
					end
					if (nonzero && csum == win[FRAME_N-1]) begin
						r.frame_ok = 1'b1;
						// Only normal-mode frames carry measurements.
						if (!diag_q) begin
							if (speed_q > top_q) begin
								top_q  = speed_q;
								peak_q = speed_q;
							end
							rpm_q   = 14'(byte_at(0)) * 14'(ekfsd_pkg::RPM_SCALE);
							spd_acc = spd_acc + byte_at(1);
							spd_cnt++;
							if (spd_cnt >= SPEED_N) begin
								speed_q     = spd_acc;
								spd_acc     = 8'h00;
								spd_cnt     = 0;
								r.speed_new = 1'b1;
							end
							err_q  = byte_at(2);
							cool_q = byte_at(3) - ekfsd_pkg::COOLANT_OFFSET;
						end
						clear_window();
					end
				end
			end
			LINK_START: begin
				win_cnt++;
				if (win_cnt >= START_LEN) begin
					diag_q  = (rx == ekfsd_pkg::DIAG_BYTE);
					link_st = LINK_RUN;
					clear_window();
				end
			end
			default: begin
				if (rx == ekfsd_pkg::START_BYTE) begin
					link_st = LINK_START;
					win_cnt = 1;
				end
			end
			endcase
		end
		r.diag_mode     = diag_q;
		r.link_running  = (link_st == LINK_RUN);
		r.rpm_value     = rpm_q;
		r.speed_value   = speed_q;
		r.coolant_value = cool_q;
		r.error_code    = err_q;
		r.peak_speed    = peak_q;
		return r;
	endfunction

	function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			bad++;
			if (bad <= 10)
				$display("%0t: %s wrong on result %0d: expected %0d, got %0d",
					$time, fname, beat_no, want, got);
		end
	endfunction

	// Predict on input beats, compare on result beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_ticks = ekfsd_pkg::OFF_TIMEOUT_RST;
			tmo_off   = 1'b0;
			drop_link();
			spd_acc   = 8'h00;
			spd_cnt   = 0;
			speed_q   = 8'h00;
			rpm_q     = '0;
			cool_q    = 8'h00;
			err_q     = 8'h00;
			top_q     = ekfsd_pkg::TOP_SPEED_INIT;
			peak_q    = 8'h00;
			expected_readings.delete();
			pending    <= 0;
			fail_count <= bad;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				ekfsd_pkg::CFG_OFF_TIMEOUT: tmo_ticks = cfg_data;
				ekfsd_pkg::CFG_TIMEOUT_DIS: tmo_off   = cfg_data[0];
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				next_r = decode_beat(s_axis_tuser, s_axis_tdata);
				expected_readings = {expected_readings, next_r};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_r = ekfsd_pkg::result_t'(m_axis_tdata[$bits(ekfsd_pkg::result_t)-1:0]);
				if (expected_readings.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: result %0d arrived with no input behind it",
							$time, beat_no);
				end else begin
					want_r = expected_readings.pop_front();
					check_field("frame_ok", 16'(want_r.frame_ok), 16'(got_r.frame_ok));
					check_field("diag_mode", 16'(want_r.diag_mode), 16'(got_r.diag_mode));
					check_field("link_running", 16'(want_r.link_running),
						16'(got_r.link_running));
					check_field("rpm_value", 16'(want_r.rpm_value), 16'(got_r.rpm_value));
					check_field("speed_value", 16'(want_r.speed_value),
						16'(got_r.speed_value));
					check_field("speed_new", 16'(want_r.speed_new), 16'(got_r.speed_new));
					check_field("coolant_value", 16'(want_r.coolant_value),
						16'(got_r.coolant_value));
					check_field("error_code", 16'(want_r.error_code),
						16'(got_r.error_code));
					check_field("peak_speed", 16'(want_r.peak_speed),
						16'(got_r.peak_speed));
					check_field("went_off", 16'(want_r.went_off), 16'(got_r.went_off));
				end
				beat_no++;
			end
			pending    <= expected_readings.size();
			fail_count <= bad;
		end
	end

endmodule

FILE: verif/ecu_kline_frame_sync_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_kline_frame_sync_decoder_unit_test: stimulus and verdict for the decoder
// Drives a short directed sequence around idle and timeout handling, then
// whole link sessions: start sequences ending in normal or diagnostic mode,
// checksummed frames mixed with broken, zero and noise bytes, and ticks that
// keep or drop the link, across several timeout settings. The sender works
// in bursts and the receiver stalls on its own pattern; a checker instance
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ecu_kline_frame_sync_decoder_unit_test;

	localparam int   START_LEN     = ekfsd_pkg::START_SEQ_LEN_DEF;
	localparam int   FRAME_N       = ekfsd_pkg::FRAME_LEN_DEF;
	localparam int   TW            = ekfsd_pkg::TIMER_W;
	localparam logic CMD_BYTE      = 1'b0;
	localparam logic CMD_TICK      = 1'b1;
	localparam int   ITEMS         = 1300;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   SETTLE_CYCLES = 6;
	localparam int   STALL_LIMIT   = 3000;

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	logic [7:0]                          s_axis_tdata;   // [7:0] rx_byte
	logic                                s_axis_tuser;   // [0] cmd
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	// [0] frame_ok, [1] diag_mode, [2] link_running, [16:3] rpm_value,
	// [24:17] speed_value, [25] speed_new, [33:26] coolant_value,
	// [41:34] error_code, [49:42] peak_speed, [50] went_off, [55:51] zero
	logic [ekfsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [ekfsd_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [TW-1:0]                       cfg_data;

	int                      fail_count;
	int                      pending;
	int unsigned             sent = 0;
	int unsigned             burst_left = 0;
	// Timeout in force while the link should stay up; 0 when ticks cannot drop it.
	int unsigned             tick_limit = 0;
	bit                      hold_req = 1'b0;

	ecu_kline_frame_sync_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ecu_kline_frame_sync_decoder_unit_check checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one beat, opening a new burst after a random gap when the last one ran out.
	task automatic send_beat(input logic cmd, input logic [7:0] data);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		sent++;
	endtask

	// Sends a received byte, sometimes preceded by ticks. The ticks normally stay
	// within the timeout; rarely they exceed it and the link drops.
	task automatic send_rx(input logic [7:0] b);
		int unsigned n;
		n = 0;
		if (tick_limit != 0 && $urandom_range(0, 149) == 0)
			n = tick_limit + 1;
		else if ($urandom_range(0, 4) == 0)
			n = $urandom_range(1, (tick_limit != 0 && tick_limit < 3) ? tick_limit : 3);
		repeat (n) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
		send_beat(CMD_BYTE, b);
	endtask

	// Stops offering and waits until every result is in and the pipeline is empty.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [ekfsd_pkg::CFG_IDX_W-1:0] idx,
			input logic [TW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_timeout(input logic [TW-1:0] ticks, input logic disable_tmo,
			input int unsigned limit);
		drain();
		write_cfg(ekfsd_pkg::CFG_OFF_TIMEOUT, ticks);
		write_cfg(ekfsd_pkg::CFG_TIMEOUT_DIS, {{(TW-1){1'b0}}, disable_tmo});
		tick_limit = limit;
	endtask

	// One link session: idle noise, start sequence, frames, then timeout ticks if set.
	task automatic run_session(input bit diag_end, input int unsigned n_frames);
		logic [7:0]  fb;
		logic [7:0]  csum;
		int unsigned kind;
		repeat ($urandom_range(0, 3)) begin
			fb = 8'($urandom_range(0, 255));
			if (fb == ekfsd_pkg::START_BYTE)
				fb = ~fb;
			send_rx(fb);
		end
		send_rx(ekfsd_pkg::START_BYTE);
		for (int i = 1; i < START_LEN; i++) begin
			fb = 8'($urandom_range(0, 255));
			if (i == START_LEN - 1)
				fb = diag_end ? ekfsd_pkg::DIAG_BYTE :
					((fb == ekfsd_pkg::DIAG_BYTE) ? ~fb : fb);
			send_rx(fb);
		end
		repeat (n_frames) begin
			kind = $urandom_range(0, 9);
			if (kind == 8) begin
				// An all-zero window has a matching checksum but must be refused.
				repeat (FRAME_N) send_rx(8'h00);
			end else if (kind == 9) begin
				repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
			end else begin
				csum = 8'h00;
				for (int k = 0; k < FRAME_N - 1; k++) begin
					fb   = 8'($urandom_range(0, 255));
					csum = csum + fb;
					send_rx(fb);
				end
				// Kind seven carries a corrupted checksum.
				send_rx((kind == 7) ? csum + 8'd1 : csum);
			end
		end
		if (tick_limit != 0)
			repeat (tick_limit + 1) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Receiver: switches between stall patterns, with one long hold on request.
	initial begin
		int unsigned mode;
		int unsigned left;
		mode = 0;
		left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= ((left % 4) == 0);
			default: m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog: too long without any beat on any channel ends the run.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Main stimulus and verdict.
	initial begin
		int unsigned t;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = CMD_BYTE;
		cfg_valid     = 1'b0;
		cfg_index     = ekfsd_pkg::CFG_OFF_TIMEOUT;
		cfg_data      = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle bytes, unarmed ticks and timeouts from idle and start.
		set_timeout(24'd1, 1'b0, 1);
		send_beat(CMD_TICK, 8'hFF);
		send_beat(CMD_BYTE, 8'hFF);
		send_beat(CMD_TICK, 8'h00);
		send_beat(CMD_TICK, 8'hFF);
		send_beat(CMD_TICK, 8'h00);
		send_beat(CMD_BYTE, 8'h00);
		send_beat(CMD_BYTE, ekfsd_pkg::START_BYTE);
		send_beat(CMD_BYTE, ekfsd_pkg::START_BYTE);
		send_beat(CMD_BYTE, ekfsd_pkg::DIAG_BYTE);
		send_beat(CMD_TICK, 8'h00);
		send_beat(CMD_TICK, 8'h00);
		send_beat(CMD_BYTE, ekfsd_pkg::DIAG_BYTE);

		// Random sessions, rotating through the timeout settings.
		for (int p = 0; p < 4 || sent < ITEMS; p++) begin
			case (p % 4)
			0: set_timeout(24'd1, 1'b0, 1);
			1: begin
				t = $urandom_range(2, 40);
				set_timeout(TW'(t), 1'b0, t);
			end
			2: set_timeout(24'hFF_FFFF, 1'b0, 0);
			default: set_timeout(24'd4, 1'b1, 0);
			endcase
			// Long receiver hold while the sender keeps offering.
			if (p == 1)
				hold_req = 1'b1;
			repeat ($urandom_range(1, 2))
				run_session(1'($urandom_range(0, 1)), $urandom_range(4, 24));
			// Settings where ticks cannot end the link: bring it down explicitly.
			if (p % 4 == 2) begin
				drain();
				write_cfg(ekfsd_pkg::CFG_OFF_TIMEOUT, 24'd3);
				repeat (5) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
			end else if (p % 4 == 3) begin
				repeat (12) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
				drain();
				write_cfg(ekfsd_pkg::CFG_TIMEOUT_DIS, '0);
				send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
			end
		end

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/ekfsd_pkg.sv
src/ekfsd_core.sv
src/ecu_kline_frame_sync_decoder_unit.sv
verif/ecu_kline_frame_sync_decoder_unit_check.sv
verif/ecu_kline_frame_sync_decoder_unit_test.sv
